>>> hw/rtl/tws_pkg.sv
`timescale 1ns / 1ps

package tws_pkg;

  // node pool and alphabet
  localparam int NODE_COUNT = 1024;
  localparam int ALPHA_SIZE = 26;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int COUNT_W    = $clog2(NODE_COUNT + 1);
  localparam int LETTER_W   = 5;
  localparam int CMD_W      = 2;

  // one memory row per node: child fields for every letter, word-end bit on top
  localparam int ROW_W      = ALPHA_SIZE * NODE_W + 1;
  localparam int BASE_W     = $clog2(ROW_W);
  localparam int WEND_BIT   = ROW_W - 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_EXACT  = 2'd1,
    CMD_PREFIX = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EVAL,
    S_CLEAR,
    S_FREAD,
    S_FEVAL,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic init_row;
    logic load_item;
    logic step;
    logic clear_row;
    logic finish;
    logic emit;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic in_walk;
    logic in_last;
    logic alloc;
    logic item_last;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/tws_if.sv
`timescale 1ns / 1ps

interface tws_req_if;
  logic                        valid;
  logic                        ready;
  logic [tws_pkg::CMD_W-1:0]    cmd;
  logic [tws_pkg::LETTER_W-1:0] letter;
  logic                        no_letter;
  logic                        last;

  modport source (output valid, output cmd, output letter, output no_letter,
                  output last, input ready);
  modport sink   (input valid, input cmd, input letter, input no_letter,
                  input last, output ready);
endinterface

interface tws_rsp_if;
  logic valid;
  logic ready;
  logic found;
  logic status;

  modport source (output valid, output found, output status, input ready);
  modport sink   (input valid, input found, input status, output ready);
endinterface

>>> hw/rtl/trie_word_store_unit.sv
`timescale 1ns / 1ps

// trie word store: lowercase words kept as a trie in a pool of 1024 nodes
// req channel: one transaction per letter of a word, with cmd (insert,
//   exact search, prefix search), letter, no_letter and last; an empty word
//   is a single transaction with no_letter and last set
// rsp channel: one transaction per word, after its last letter; found for
//   searches, status 1 when an insert ran out of nodes
// each node is one memory row holding all 26 child links and a word-end bit
// a walking letter is taken while its node's row is read, then evaluated;
//   one that adds a node also passes a clear that zeroes the new node's row;
//   req is ready only in idle, so the next letter waits for these steps
// before rsp.valid rises, a last transaction that walks nothing passes the
//   word-end read or update and the result register; one that walks first
//   passes evaluate, a new row's clear if it adds one, final node re-read
// reset: after rst drops, the init state zeroes the root row, and req is
//   not ready then; the pool restarts holding only the root
// a stalled rsp holds its transaction; the next word's letters are still
//   taken, but its result waits until the held one is taken
module trie_word_store_unit (
  input  logic      clk,
  input  logic      rst,
  tws_req_if.sink   req,
  tws_rsp_if.source rsp
);

  tws_pkg::ctl_t ctl;
  tws_pkg::sts_t sts;

  // state machine: sequencing of read, evaluate, allocate and finish steps
  tws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // node memory, walk state and result register
  tws_dpath u_dpath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .ctl (ctl),
    .sts (sts)
  );

endmodule

>>> hw/rtl/tws_ctrl.sv
`timescale 1ns / 1ps

module tws_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  tws_pkg::sts_t  sts,
  output tws_pkg::ctl_t  ctl
);

  tws_pkg::state_t state;
  tws_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tws_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    req_ready  = 1'b0;
    case (state)
      tws_pkg::S_INIT: begin
        ctl.init_row = 1'b1;
        state_next   = tws_pkg::S_IDLE;
      end
      tws_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctl.load_item = 1'b1;
          if (sts.in_walk) begin
            state_next = tws_pkg::S_EVAL;
          end else if (sts.in_last) begin
            // row of the current node is already being read
            state_next = tws_pkg::S_FEVAL;
          end
        end
      end
      tws_pkg::S_EVAL: begin
        ctl.step = 1'b1;
        if (sts.alloc) begin
          state_next = tws_pkg::S_CLEAR;
        end else if (sts.item_last) begin
          state_next = tws_pkg::S_FREAD;
        end else begin
          state_next = tws_pkg::S_IDLE;
        end
      end
      tws_pkg::S_CLEAR: begin
        ctl.clear_row = 1'b1;
        state_next    = sts.item_last ? tws_pkg::S_FREAD : tws_pkg::S_IDLE;
      end
      tws_pkg::S_FREAD: begin
        state_next = tws_pkg::S_FEVAL;
      end
      tws_pkg::S_FEVAL: begin
        ctl.finish = 1'b1;
        state_next = tws_pkg::S_OUT;
      end
      tws_pkg::S_OUT: begin
        if (sts.out_free) begin
          ctl.emit   = 1'b1;
          state_next = tws_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tws_pkg::S_INIT;
      end
    endcase
  end

endmodule

>>> hw/rtl/tws_dpath.sv
`timescale 1ns / 1ps

module tws_dpath (
  input  logic           clk,
  input  logic           rst,
  tws_req_if.sink        req,
  tws_rsp_if.source      rsp,
  input  tws_pkg::ctl_t  ctl,
  output tws_pkg::sts_t  sts
);

  // node rows, one per pool entry
  logic [tws_pkg::ROW_W-1:0] mem [tws_pkg::NODE_COUNT];
  logic [tws_pkg::ROW_W-1:0] rdata;

  logic [tws_pkg::NODE_W-1:0]   cur_node;
  logic [tws_pkg::COUNT_W-1:0]  nodes_used;
  logic                         path_missing;
  logic                         pool_full_seen;

  logic [tws_pkg::CMD_W-1:0]    item_cmd;
  logic [tws_pkg::LETTER_W-1:0] item_letter;
  logic                         item_last;

  logic found_res;
  logic status_res;
  logic out_valid;
  logic out_found;
  logic out_status;

  logic [tws_pkg::BASE_W-1:0]  base;
  logic [tws_pkg::NODE_W-1:0]  child;
  logic                        pool_full;
  logic                        is_insert;
  logic                        is_exact;
  logic                        alloc;
  logic                        mark_end;
  logic                        mem_we;
  logic [tws_pkg::NODE_W-1:0]  mem_waddr;
  logic [tws_pkg::ROW_W-1:0]   mem_wdata;
  logic [tws_pkg::NODE_W-1:0]  new_node;

  assign base      = tws_pkg::BASE_W'(item_letter) * tws_pkg::BASE_W'(tws_pkg::NODE_W);
  assign child     = rdata[base +: tws_pkg::NODE_W];
  assign pool_full = (nodes_used == tws_pkg::COUNT_W'(tws_pkg::NODE_COUNT));
  assign is_insert = (item_cmd == tws_pkg::CMD_INSERT);
  assign is_exact  = (item_cmd == tws_pkg::CMD_EXACT);
  assign alloc     = (child == '0) && is_insert && !pool_full;
  assign mark_end  = is_insert && !path_missing && !pool_full_seen;
  assign new_node  = nodes_used[tws_pkg::NODE_W-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_node;
    mem_wdata = rdata;
    if (ctl.init_row) begin
      mem_we    = 1'b1;
      mem_waddr = '0;
      mem_wdata = '0;
    end else if (ctl.step && alloc) begin
      mem_we                            = 1'b1;
      mem_wdata[base +: tws_pkg::NODE_W] = new_node;
    end else if (ctl.clear_row) begin
      mem_we    = 1'b1;
      mem_waddr = new_node;
      mem_wdata = '0;
    end else if (ctl.finish && mark_end) begin
      mem_we                      = 1'b1;
      mem_wdata[tws_pkg::WEND_BIT] = 1'b1;
    end
  end

  // row of the current node is read every cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[cur_node];
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item_cmd    <= req.cmd;
      item_letter <= req.letter;
      item_last   <= req.last;
    end
    if (ctl.finish) begin
      found_res  <= is_exact ? (!path_missing && rdata[tws_pkg::WEND_BIT])
                  : (is_insert ? 1'b0 : !path_missing);
      status_res <= is_insert && pool_full_seen;
    end
    if (ctl.emit) begin
      out_found  <= found_res;
      out_status <= status_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_node       <= '0;
      nodes_used     <= tws_pkg::COUNT_W'(1);
      path_missing   <= 1'b0;
      pool_full_seen <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (ctl.step) begin
        if (child != '0) begin
          cur_node <= child;
        end else if (is_insert && pool_full) begin
          pool_full_seen <= 1'b1;
          path_missing   <= 1'b1;
        end else if (!is_insert) begin
          path_missing <= 1'b1;
        end
      end
      if (ctl.clear_row) begin
        cur_node   <= new_node;
        nodes_used <= nodes_used + tws_pkg::COUNT_W'(1);
      end
      if (ctl.emit) begin
        cur_node       <= '0;
        path_missing   <= 1'b0;
        pool_full_seen <= 1'b0;
        out_valid      <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.in_walk   = !req.no_letter
                         && (req.letter < tws_pkg::LETTER_W'(tws_pkg::ALPHA_SIZE))
                         && !path_missing;
  assign sts.in_last   = req.last;
  assign sts.alloc     = alloc;
  assign sts.item_last = item_last;
  assign sts.out_free  = !out_valid || rsp.ready;

  assign rsp.valid  = out_valid;
  assign rsp.found  = out_found;
  assign rsp.status = out_status;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

// checks the trie word store against its own trie model kept here:
// a directed opening, four idling phases of random words, then a phase
// that fills the node pool and keeps working once it is full
module testbench;
  import tws_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;     // long receiver hold-off
  localparam int PHASE_ITEMS = 160;     // letter transactions per idling phase
  localparam int MAX_LEN     = 8;       // longest word the generator makes
  localparam int KNOWN_MAX   = 48;      // words kept around for repeat searches

  // one word result as the rsp channel carries it
  typedef struct packed {
    logic found;
    logic status;
  } word_result_t;

  // a word as a length and up to MAX_LEN letter codes
  typedef struct packed {
    logic [3:0]                        len;
    logic [MAX_LEN-1:0][LETTER_W-1:0]  ch;
  } word_t;

  // trie model plus the queue of word results still owed by the block
  class trie_scoreboard;
    bit [NODE_W-1:0] kids [NODE_COUNT*ALPHA_SIZE];  // 0 = no child
    bit              word_end [NODE_COUNT];
    int unsigned     nodes_used = 1;                 // root only
    int unsigned     cur_node;
    bit              walk_stopped;
    bit              out_of_nodes;
    word_result_t    expected_q [$];
    int              mismatches;
    int              results_seen;
    int              found_count;
    int              full_count;

    // walks one accepted letter transaction, queues a result on the last one
    function void note_request(cmd_t c, logic [LETTER_W-1:0] l, logic nl, logic ls);
      int unsigned  slot;
      int unsigned  nxt;
      word_result_t r;
      if (!nl && l < ALPHA_SIZE && !walk_stopped) begin
        slot = cur_node * ALPHA_SIZE + l;
        nxt  = kids[slot];
        if (nxt == 0) begin
          if (c == CMD_INSERT) begin
            if (nodes_used >= NODE_COUNT) begin
              out_of_nodes = 1'b1;
              walk_stopped = 1'b1;
            end else begin
              nxt = nodes_used;
              nodes_used++;
              kids[slot] = NODE_W'(nxt);
            end
          end else begin
            walk_stopped = 1'b1;
          end
        end
        if (!walk_stopped) cur_node = nxt;
      end
      if (ls) begin
        r = '0;
        case (c)
          CMD_INSERT: begin
            if (!walk_stopped && !out_of_nodes) word_end[cur_node] = 1'b1;
            r.status = out_of_nodes;
          end
          CMD_EXACT: begin
            if (!walk_stopped) r.found = word_end[cur_node];
          end
          default: begin
            r.found = !walk_stopped;
          end
        endcase
        if (r.found) found_count++;
        if (r.status) full_count++;
        expected_q.push_back(r);
        cur_node     = 0;
        walk_stopped = 1'b0;
        out_of_nodes = 1'b0;
      end
    endfunction

    function void check_response(logic f, logic s);
      word_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing pending: found=%0b status=%0b", f, s);
        return;
      end
      want = expected_q.pop_front();
      if (f !== want.found || s !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word result %0d: expected found=%0b status=%0b, got found=%0b status=%0b",
                   results_seen, want.found, want.status, f, s);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  tws_req_if req ();
  tws_rsp_if rsp ();

  trie_word_store_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  trie_scoreboard sb = new();

  int    send_idle_pct;   // chance per cycle that the sender holds back
  int    stall_pct;       // chance per cycle that the receiver stalls
  int    hold_requests;   // bumped by the stimulus, served by the receiver
  int    hold_served;
  int    hold_left;
  int    items_sent;      // letter transactions that do work (ignored ones left out)
  int    cycles;
  word_t known [$];       // recently inserted words, reused for searches

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // cycle counter and run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d results outstanding",
               cycles, sb.pending());
      $display("[trie_word_store_unit] ERROR");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off when one is requested
  // the hold-off is counted here so the sender keeps offering meanwhile
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // every accepted result transaction goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) sb.check_response(rsp.found, rsp.status);
  end

  // one letter transaction; called and returns at a falling edge
  // random idle cycles come first, valid only drops while idling
  task automatic send_item(cmd_t c, logic [LETTER_W-1:0] l, logic nl, logic ls);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid     <= 1'b1;
    req.cmd       <= c;
    req.letter    <= l;
    req.no_letter <= nl;
    req.last      <= ls;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(c, l, nl, ls);
    if (!(nl && !ls)) items_sent++;
    @(negedge clk);
  endtask

  // a whole word under one command; the empty word is one no-letter transaction
  task automatic send_word(cmd_t c, word_t w);
    if (w.len == 0) begin
      send_item(c, LETTER_W'($urandom_range(31)), 1'b1, 1'b1);
    end else begin
      for (int i = 0; i < w.len; i++)
        send_item(c, w.ch[i], 1'b0, i == w.len - 1);
    end
  endtask

  // sender pause: nothing offered until every owed result has come back
  task automatic wait_drained();
    req.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // narrow words stay on a few letters so that searches often hit
  function automatic word_t fresh_word(int len, bit wide);
    word_t w;
    w     = '0;
    w.len = 4'(len);
    for (int i = 0; i < len; i++) begin
      if (!wide && $urandom_range(9) < 7) w.ch[i] = LETTER_W'($urandom_range(3));
      else w.ch[i] = LETTER_W'($urandom_range(ALPHA_SIZE - 1));
    end
    return w;
  endfunction

  function automatic void remember(word_t w);
    known.push_back(w);
    if (known.size() > KNOWN_MAX) known.delete(0);
  endfunction

  // per-transaction commands, out-of-range letters, stray no-letter items
  task automatic noise_word();
    int                  len;
    cmd_t                c;
    logic [LETTER_W-1:0] l;
    logic                nl;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      c  = cmd_t'($urandom_range(3));
      l  = ($urandom_range(9) < 8) ? LETTER_W'($urandom_range(3))
                                   : LETTER_W'($urandom_range(ALPHA_SIZE, 31));
      nl = ($urandom_range(9) == 0);
      send_item(c, l, nl, i == len - 1);
    end
  endtask

  // mostly well-formed inserts and searches of words already stored
  task automatic random_word();
    word_t w;
    int    pick;
    pick = $urandom_range(99);
    if (pick < 35 || (pick < 70 && known.size() == 0)) begin
      w = fresh_word($urandom_range(1, 6), 1'b0);
      send_word(CMD_INSERT, w);
      remember(w);
    end else if (pick < 55) begin
      // exact search of a stored word, sometimes a prefix of it
      w = known[$urandom_range(known.size() - 1)];
      if ($urandom_range(3) == 0) w.len = 4'($urandom_range(w.len));
      send_word(CMD_EXACT, w);
    end else if (pick < 70) begin
      w     = known[$urandom_range(known.size() - 1)];
      w.len = 4'($urandom_range(w.len));
      send_word(($urandom_range(4) == 0) ? CMD_SPARE : CMD_PREFIX, w);
    end else if (pick < 80) begin
      // likely misses
      w = fresh_word($urandom_range(1, 6), 1'b0);
      send_word(($urandom_range(1) == 0) ? CMD_EXACT : CMD_PREFIX, w);
    end else if (pick < 88) begin
      send_word(cmd_t'($urandom_range(3)), '0);
    end else begin
      noise_word();
    end
  endtask

  task automatic run_random(int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) random_word();
  endtask

  task automatic directed_checks();
    // empty word on a fresh trie: not a stored word, always a prefix
    send_item(CMD_EXACT, '0, 1'b1, 1'b1);
    send_item(CMD_PREFIX, LETTER_W'(31), 1'b1, 1'b1);
    // first and last letter
    send_item(CMD_INSERT, LETTER_W'(0), 1'b0, 1'b1);
    send_item(CMD_EXACT, LETTER_W'(0), 1'b0, 1'b1);
    send_item(CMD_INSERT, LETTER_W'(25), 1'b0, 1'b1);
    send_item(CMD_PREFIX, LETTER_W'(25), 1'b0, 1'b1);
    send_item(CMD_EXACT, LETTER_W'(1), 1'b0, 1'b1);
    // empty word stored at the root
    send_item(CMD_INSERT, '0, 1'b1, 1'b1);
    send_item(CMD_EXACT, '0, 1'b1, 1'b1);
    // out-of-range letters act as no letter
    send_item(CMD_EXACT, LETTER_W'(31), 1'b0, 1'b1);
    send_item(CMD_SPARE, LETTER_W'(ALPHA_SIZE), 1'b0, 1'b1);
    // spare command behaves as a prefix search
    send_item(CMD_SPARE, LETTER_W'(0), 1'b0, 1'b1);
    // a no-letter item inside a word is skipped
    send_item(CMD_INSERT, LETTER_W'(2), 1'b0, 1'b0);
    send_item(CMD_INSERT, LETTER_W'(9), 1'b1, 1'b0);
    send_item(CMD_INSERT, LETTER_W'(3), 1'b0, 1'b1);
    send_item(CMD_EXACT, LETTER_W'(2), 1'b0, 1'b0);
    send_item(CMD_EXACT, LETTER_W'(3), 1'b0, 1'b1);
    // search miss stops the walk, the insert after it creates nothing
    send_item(CMD_PREFIX, LETTER_W'(16), 1'b0, 1'b0);
    send_item(CMD_INSERT, LETTER_W'(17), 1'b0, 1'b1);
    send_item(CMD_PREFIX, LETTER_W'(16), 1'b0, 1'b1);
    // insert letter then exact miss: node made, no word-end mark
    send_item(CMD_INSERT, LETTER_W'(4), 1'b0, 1'b0);
    send_item(CMD_EXACT, LETTER_W'(5), 1'b0, 1'b1);
    send_item(CMD_EXACT, LETTER_W'(4), 1'b0, 1'b1);
    send_item(CMD_PREFIX, LETTER_W'(4), 1'b0, 1'b1);
  endtask

  initial begin
    word_t w;
    rst           = 1'b1;
    req.valid     = 1'b0;
    req.cmd       = CMD_INSERT;
    req.letter    = '0;
    req.no_letter = 1'b0;
    req.last      = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    directed_checks();

    // no idling; a long receiver hold-off midway fills the block up
    run_random(PHASE_ITEMS / 2);
    hold_requests++;
    run_random(PHASE_ITEMS / 2);

    // sparse sender, with one pause until everything has drained
    send_idle_pct = 86;
    run_random(PHASE_ITEMS / 2);
    wait_drained();
    run_random(PHASE_ITEMS / 2);

    // slow receiver
    send_idle_pct = 0;
    stall_pct     = 86;
    run_random(PHASE_ITEMS);

    // both sides idling now and then
    send_idle_pct = 27;
    stall_pct     = 27;
    run_random(PHASE_ITEMS);

    // long wide words use up the pool; keep going past the first full report
    while (sb.full_count < 4) begin
      if ($urandom_range(3) == 0) begin
        random_word();
      end else begin
        w = fresh_word(MAX_LEN, 1'b1);
        send_word(CMD_INSERT, w);
        remember(w);
      end
    end
    run_random(80);

    wait_drained();
    repeat (24) @(posedge clk);

    $display("sent %0d letter transactions over four idling phases and a pool-filling phase",
             items_sent);
    $display("checked %0d word results: %0d found, %0d pool full, %0d of %0d nodes in use",
             sb.results_seen, sb.found_count, sb.full_count, sb.nodes_used, NODE_COUNT);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[trie_word_store_unit] OK");
    end else begin
      $display("%0d mismatches, %0d results never came", sb.mismatches, sb.pending());
      $display("[trie_word_store_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/tws_pkg.sv
hw/rtl/tws_if.sv
hw/rtl/tws_ctrl.sv
hw/rtl/tws_dpath.sv
hw/rtl/trie_word_store_unit.sv
test/testbench.sv
